FILE: rtl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types, constants and the arctangent table for the axis-angle
// rotation matrix generator.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int OUTPUT_FRAC_BITS = 30;
    localparam int CORDIC_STEPS     = 24;

    typedef struct packed {
        logic signed [31:0] angle_deg;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic               zero_axis;
        logic               last;
    } t_out_item;

    typedef logic [2:0][31:0] t_mag3;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } t_flags;

    // square root stage: remainder, partial root, axis magnitudes riding along
    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] root;
        t_mag3       mag;
    } t_sq_st;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] num_lo;
        logic [30:0] quo;
    } t_dv_lane;

    typedef struct packed {
        logic [31:0]         div;
        t_dv_lane [2:0]      lane;
    } t_dv_st;

    // degree to phase conversion: long division by 360, four bits a stage
    typedef struct packed {
        logic [59:0] num;
        logic [8:0]  rem;
        logic [31:0] quo;
    } t_ad_st;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] ang;
        logic               flip;
    } t_cr_st;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
    } t_cs;

    // atan(2^-i) in turns, one turn = 2^32
    function automatic logic [29:0] atan_turns(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            5'd31: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Builds the 4x4 rotation matrix for an angle in degrees about an arbitrary
// axis and streams its sixteen elements in flat order.
// ----------------------------------------------------------------------------
// Each accepted item yields sixteen result transfers, one per cycle while
// i_out_stall is low, so the single result channel limits the block to one
// item per sixteen transfers. Behind it sits a pipeline of 74 register stages
// (axis magnitude and normalization, a one-bit-per-stage square root, three
// one-bit-per-stage dividers for the unit axis, a degree-to-phase divider and
// CORDIC running alongside, then the product and rounding stages), and a new
// item can enter while earlier ones are still in flight. With skip_zero_angle
// set (reset value), an angle of exactly zero is taken and produces nothing.
// An all-zero axis flags zero_axis on every element and emits the identity
// matrix.
module axis_angle_rotation_matrix
    import aarm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int SQ_STEPS  = 32;
    localparam int DV_STEPS  = 31;
    localparam int AD_STEPS  = 15;
    localparam int K_DV_END  = 5 + SQ_STEPS + 1 + DV_STEPS;
    localparam int K_CS      = 18 + CORDIC_STEPS;
    localparam int CS_DLY    = K_DV_END - K_CS;
    localparam int K_OUT     = K_DV_END + 4;
    localparam int DROP      = 30 - OUTPUT_FRAC_BITS;

    localparam logic signed [35:0] RND_ADD  = 36'sd1 <<< DROP >>> 1;
    localparam logic signed [35:0] ONE_OUT  = 36'sd1 <<< OUTPUT_FRAC_BITS;
    localparam logic signed [33:0] Q30_ONE  = 34'sd1073741824;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [59:0]        PHASE_OFS = (60'd360 << 48) + 60'd180;
    localparam logic [9:0]         DEG360   = 10'd360;
    localparam logic [3:0]         LAST_IDX = 4'd15;

    // ---------------------------------------------------------------- helpers
    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    function automatic logic [4:0] norm_shift(input logic [31:0] m);
        logic [4:0] pos;
        pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) pos = 5'(i);
        end
        return (pos >= 5'd30) ? 5'd0 : 5'd30 - pos;
    endfunction

    function automatic t_sq_st sq_step(input t_sq_st s, input int i);
        t_sq_st      o;
        logic [63:0] trial;
        o     = s;
        trial = (64'(s.root) << (i + 1)) + (64'd1 << (2 * i));
        if (s.rem >= trial) begin
            o.rem  = s.rem - trial;
            o.root = s.root | (32'd1 << i);
        end
        return o;
    endfunction

    function automatic t_dv_lane dv_step(input t_dv_lane l, input logic [31:0] d,
                                         input logic [4:0] b);
        t_dv_lane    o;
        logic [32:0] r;
        o = l;
        r = {l.rem, l.num_lo[b]};
        if (r >= {1'b0, d}) begin
            r        = r - {1'b0, d};
            o.quo[b] = 1'b1;
        end
        o.rem = r[31:0];
        return o;
    endfunction

    function automatic t_ad_st ad_step(input t_ad_st s);
        t_ad_st     o;
        logic [9:0] r;
        logic [8:0] rm;
        logic [3:0] qb;
        rm = s.rem;
        qb = '0;
        for (int b = 0; b < 4; b++) begin
            r = {rm, s.num[59 - b]};
            if (r >= DEG360) begin
                r          = r - DEG360;
                qb[3 - b]  = 1'b1;
            end
            rm = r[8:0];
        end
        o.num = s.num << 4;
        o.rem = rm;
        o.quo = {s.quo[27:0], qb};
        return o;
    endfunction

    function automatic t_cr_st cr_step(input t_cr_st s, input logic [4:0] i);
        t_cr_st             o;
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        xs     = s.x >>> i;
        ys     = s.y >>> i;
        o.flip = s.flip;
        if (!s.ang[33]) begin
            o.x   = s.x - ys;
            o.y   = s.y + xs;
            o.ang = s.ang - 34'(atan_turns(i));
        end else begin
            o.x   = s.x + ys;
            o.y   = s.y - xs;
            o.ang = s.ang + 34'(atan_turns(i));
        end
        return o;
    endfunction

    function automatic logic signed [31:0] clamp30(input logic signed [33:0] v,
                                                   input logic flip);
        logic signed [33:0] w;
        w = flip ? -v : v;
        if (w > Q30_ONE) w = Q30_ONE;
        else if (w < -Q30_ONE) w = -Q30_ONE;
        return w[31:0];
    endfunction

    function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b);
        p = (p + (68'sd1 <<< 29)) >>> 30;
        return p[33:0];
    endfunction

    function automatic logic signed [31:0] rnd_sat(input logic signed [35:0] v);
        logic signed [35:0] w;
        w = (v + RND_ADD) >>> DROP;
        if (w > ONE_OUT) w = ONE_OUT;
        else if (w < -ONE_OUT) w = -ONE_OUT;
        return w[31:0];
    endfunction

    // ---------------------------------------------------------------- state
    logic               r_skip;
    logic [K_OUT:0]     r_v;
    logic               n_v0;
    logic               w_en;
    logic               w_load;
    logic               w_out_xfer;

    t_in_item           r_in;
    t_mag3              r_mag1, n_mag1;
    logic [31:0]        r_max1, n_max1;
    t_flags             r_fl [1:K_OUT];
    t_flags             n_fl1;
    t_mag3              r_m2;
    logic [4:0]         r_sh2, n_sh2;
    t_mag3              r_m3, n_m3;
    logic [2:0][63:0]   r_sq4, n_sq4;
    t_mag3              r_m4;

    t_sq_st             r_sq [0:SQ_STEPS];
    t_sq_st             n_sq [0:SQ_STEPS];
    t_dv_st             r_dv [0:DV_STEPS];
    t_dv_st             n_dv [0:DV_STEPS];
    t_ad_st             r_ad [0:AD_STEPS];
    t_ad_st             n_ad [0:AD_STEPS];
    t_cr_st             r_cr [0:CORDIC_STEPS];
    t_cr_st             n_cr [0:CORDIC_STEPS];
    t_cs                r_cs [0:CS_DLY];
    t_cs                n_cs [0:CS_DLY];

    logic signed [33:0] r_tu1 [0:2];
    logic signed [33:0] n_tu1 [0:2];
    logic signed [33:0] r_su1 [0:2];
    logic signed [33:0] n_su1 [0:2];
    logic signed [31:0] r_u1  [0:2];
    logic signed [31:0] n_u1  [0:2];
    logic signed [31:0] r_c1;
    logic signed [33:0] r_pp2 [0:5];
    logic signed [33:0] n_pp2 [0:5];
    logic signed [33:0] r_su2 [0:2];
    logic signed [31:0] r_c2;
    logic signed [35:0] r_e3  [0:8];
    logic signed [35:0] n_e3  [0:8];
    logic signed [31:0] r_e4  [0:8];
    logic signed [31:0] n_e4  [0:8];

    logic               r_busy;
    logic [3:0]         r_cnt;
    logic signed [31:0] r_el [0:8];
    logic               r_zero;

    // ---------------------------------------------------------------- control
    assign w_out_xfer = r_busy && !i_out_stall;
    assign w_load     = !r_busy || (w_out_xfer && (r_cnt == LAST_IDX));
    assign w_en       = !r_v[K_OUT] || w_load;
    assign o_in_stall = !w_en;
    // drop a zero angle under the rotate rule right at the input
    assign n_v0       = i_in_valid && !(r_skip && (i_in_data.angle_deg == 32'sd0));

    // ---------------------------------------------------------------- datapath
    always_comb begin
        logic [59:0] xa;
        n_mag1[0] = abs32(r_in.axis_x);
        n_mag1[1] = abs32(r_in.axis_y);
        n_mag1[2] = abs32(r_in.axis_z);
        n_max1    = n_mag1[0];
        if (n_mag1[1] > n_max1) n_max1 = n_mag1[1];
        if (n_mag1[2] > n_max1) n_max1 = n_mag1[2];
        n_fl1.neg  = {r_in.axis_z[31], r_in.axis_y[31], r_in.axis_x[31]};
        n_fl1.zero = (n_max1 == 32'd0);

        // floor((deg*2^16 + 180) / 360) mod 2^32 is the wrapped phase; the
        // offset of 360*2^48 keeps the dividend positive without moving it
        xa = ({{28{r_in.angle_deg[31]}}, r_in.angle_deg} << 16) + PHASE_OFS;
        n_ad[0].num = xa;
        n_ad[0].rem = '0;
        n_ad[0].quo = '0;
        for (int s = 1; s <= AD_STEPS; s++) begin
            n_ad[s] = ad_step(r_ad[s - 1]);
        end

        n_sh2 = norm_shift(r_max1);
        for (int k = 0; k < 3; k++) begin
            n_m3[k]  = r_m2[k] << r_sh2;
            n_sq4[k] = 64'(r_m3[k]) * 64'(r_m3[k]);
        end

        n_sq[0].rem  = r_sq4[0] + r_sq4[1] + r_sq4[2];
        n_sq[0].root = '0;
        n_sq[0].mag  = r_m4;
        for (int j = 1; j <= SQ_STEPS; j++) begin
            n_sq[j] = sq_step(r_sq[j - 1], SQ_STEPS - j);
        end

        n_dv[0].div = r_sq[SQ_STEPS].root;
        for (int k = 0; k < 3; k++) begin
            logic [61:0] num;
            num = {r_sq[SQ_STEPS].mag[k], 30'd0} + 62'(r_sq[SQ_STEPS].root >> 1);
            n_dv[0].lane[k].rem    = 32'(num[61:31]);
            n_dv[0].lane[k].num_lo = num[30:0];
            n_dv[0].lane[k].quo    = '0;
        end
        for (int j = 1; j <= DV_STEPS; j++) begin
            n_dv[j].div = r_dv[j - 1].div;
            for (int k = 0; k < 3; k++) begin
                n_dv[j].lane[k] = dv_step(r_dv[j - 1].lane[k], r_dv[j - 1].div,
                                          5'(DV_STEPS - j));
            end
        end
    end

    // CORDIC on the folded phase
    always_comb begin
        logic signed [31:0] a;
        a = signed'(r_ad[AD_STEPS].quo);
        n_cr[0].x = CORDIC_X0;
        n_cr[0].y = '0;
        if (a > 32'sd1073741824 || a < -32'sd1073741824) begin
            // move by half a turn: flips the sign bit exactly
            n_cr[0].ang  = 34'(signed'({~a[31], a[30:0]}));
            n_cr[0].flip = 1'b1;
        end else begin
            n_cr[0].ang  = 34'(a);
            n_cr[0].flip = 1'b0;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            n_cr[i + 1] = cr_step(r_cr[i], 5'(i));
        end
        n_cs[0].c = clamp30(r_cr[CORDIC_STEPS].x, r_cr[CORDIC_STEPS].flip);
        n_cs[0].s = clamp30(r_cr[CORDIC_STEPS].y, r_cr[CORDIC_STEPS].flip);
        for (int d = 1; d <= CS_DLY; d++) begin
            n_cs[d] = r_cs[d - 1];
        end
    end

    // products, sums, rounding
    always_comb begin
        logic signed [33:0] t;
        t = Q30_ONE - 34'(r_cs[CS_DLY].c);
        for (int k = 0; k < 3; k++) begin
            n_u1[k] = r_fl[K_DV_END].neg[k] ? -32'(r_dv[DV_STEPS].lane[k].quo)
                                             :  32'(r_dv[DV_STEPS].lane[k].quo);
            n_tu1[k] = mul30(t, 34'(n_u1[k]));
            n_su1[k] = mul30(34'(r_cs[CS_DLY].s), 34'(n_u1[k]));
        end

        n_pp2[0] = mul30(r_tu1[0], 34'(r_u1[0]));
        n_pp2[1] = mul30(r_tu1[0], 34'(r_u1[1]));
        n_pp2[2] = mul30(r_tu1[0], 34'(r_u1[2]));
        n_pp2[3] = mul30(r_tu1[1], 34'(r_u1[1]));
        n_pp2[4] = mul30(r_tu1[1], 34'(r_u1[2]));
        n_pp2[5] = mul30(r_tu1[2], 34'(r_u1[2]));

        n_e3[0] = 36'(r_pp2[0]) + 36'(r_c2);
        n_e3[1] = 36'(r_pp2[1]) + 36'(r_su2[2]);
        n_e3[2] = 36'(r_pp2[2]) - 36'(r_su2[1]);
        n_e3[3] = 36'(r_pp2[1]) - 36'(r_su2[2]);
        n_e3[4] = 36'(r_pp2[3]) + 36'(r_c2);
        n_e3[5] = 36'(r_pp2[4]) + 36'(r_su2[0]);
        n_e3[6] = 36'(r_pp2[2]) + 36'(r_su2[1]);
        n_e3[7] = 36'(r_pp2[4]) - 36'(r_su2[0]);
        n_e3[8] = 36'(r_pp2[5]) + 36'(r_c2);

        for (int e = 0; e < 9; e++) begin
            n_e4[e] = rnd_sat(r_e3[e]);
        end
        // zero axis: identity on the diagonal
        if (r_fl[K_OUT - 1].zero) begin
            for (int e = 0; e < 9; e++) begin
                n_e4[e] = ((e == 0) || (e == 4) || (e == 8)) ? ONE_OUT[31:0] : 32'sd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in      <= i_in_data;
            r_mag1    <= n_mag1;
            r_max1    <= n_max1;
            r_fl[1]   <= n_fl1;
            for (int k = 2; k <= K_OUT; k++) r_fl[k] <= r_fl[k - 1];
            r_m2      <= r_mag1;
            r_sh2     <= n_sh2;
            r_m3      <= n_m3;
            r_sq4     <= n_sq4;
            r_m4      <= r_m3;
            for (int j = 0; j <= SQ_STEPS; j++) r_sq[j] <= n_sq[j];
            for (int j = 0; j <= DV_STEPS; j++) r_dv[j] <= n_dv[j];
            for (int j = 0; j <= AD_STEPS; j++) r_ad[j] <= n_ad[j];
            for (int j = 0; j <= CORDIC_STEPS; j++) r_cr[j] <= n_cr[j];
            for (int j = 0; j <= CS_DLY; j++) r_cs[j] <= n_cs[j];
            for (int k = 0; k < 3; k++) begin
                r_tu1[k] <= n_tu1[k];
                r_su1[k] <= n_su1[k];
                r_u1[k]  <= n_u1[k];
                r_su2[k] <= r_su1[k];
            end
            r_c1 <= r_cs[CS_DLY].c;
            r_c2 <= r_c1;
            for (int k = 0; k < 6; k++) r_pp2[k] <= n_pp2[k];
            for (int e = 0; e < 9; e++) begin
                r_e3[e] <= n_e3[e];
                r_e4[e] <= n_e4[e];
            end
        end
        if (r_v[K_OUT] && w_load) begin
            for (int e = 0; e < 9; e++) r_el[e] <= r_e4[e];
            r_zero <= r_fl[K_OUT].zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b1;
            r_v    <= '0;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) r_skip <= i_cfg_wdata;
            if (w_en) r_v <= {r_v[K_OUT-1:0], n_v0};
            // load a finished matrix, else advance through its elements
            if (r_v[K_OUT] && w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_out_xfer) begin
                if (r_cnt == LAST_IDX) r_busy <= 1'b0;
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_comb begin
        o_out_data.element_index = r_cnt;
        o_out_data.zero_axis     = r_zero;
        o_out_data.last          = (r_cnt == LAST_IDX);
        unique case (r_cnt)
            4'd0:    o_out_data.element_value = r_el[0];
            4'd1:    o_out_data.element_value = r_el[1];
            4'd2:    o_out_data.element_value = r_el[2];
            4'd4:    o_out_data.element_value = r_el[3];
            4'd5:    o_out_data.element_value = r_el[4];
            4'd6:    o_out_data.element_value = r_el[5];
            4'd8:    o_out_data.element_value = r_el[6];
            4'd9:    o_out_data.element_value = r_el[7];
            4'd10:   o_out_data.element_value = r_el[8];
            4'd15:   o_out_data.element_value = ONE_OUT[31:0];
            default: o_out_data.element_value = 32'sd0;
        endcase
    end

    assign o_out_valid = r_busy;

endmodule

FILE: tb/axis_angle_rotation_matrix_tb.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_tb
// Streams angle/axis items into the rotation matrix generator and checks all
// sixteen elements of every matrix against a bit-accurate predictor, under
// both skip-zero settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_tb;
    import aarm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int        PIPE_DEPTH  = 74;
    localparam int        IDLE_LIMIT  = 20000;
    localparam int        N_RANDOM    = 500;
    localparam int        N_DIRECTED  = 20;
    localparam logic signed [63:0] Q30_ONE = 64'sd1 <<< 30;

    // directed rows: field values plus a typed-in expectation where obvious
    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_IDENT
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        logic      skip;
        t_in_item  item;
    } t_row;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      in_valid;
    t_in_item  in_data;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall;

    t_out_item matrix_q[$];
    logic      skip_zero;
    int        err_cnt;
    int        idle_cycles;
    int        stall_mode;
    t_row      rows[N_DIRECTED];

    axis_angle_rotation_matrix u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [63:0] fshift(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        return fshift(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic logic signed [63:0] clamp1(input logic signed [63:0] v,
                                                   input logic signed [63:0] one);
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // cos and sin of a Q16.16 degree angle, Q2.30
    task automatic cordic_cs(input logic signed [31:0] deg,
                             output logic signed [63:0] co, output logic signed [63:0] si);
        logic signed [63:0] r;
        logic signed [63:0] a;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] nx;
        logic [63:0]        ph;
        logic               flip;
        r = 64'(deg) % 64'sd23592960;
        if (r < 0) r = r + 64'sd23592960;
        ph = ((64'(r) * 64'd65536 + 64'd180) / 64'd360) & 64'hFFFF_FFFF;
        a = 64'(signed'(ph[31:0]));
        flip = 1'b0;
        if (a > 64'(Q30_ONE)) begin
            a = a - (64'sd1 <<< 31);
            flip = 1'b1;
        end else if (a < -64'(Q30_ONE)) begin
            a = a + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            if (a >= 0) begin
                nx = x - fshift(y, i);
                y = y + fshift(x, i);
                a = a - 64'(atan_turns(5'(i)));
            end else begin
                nx = x + fshift(y, i);
                y = y - fshift(x, i);
                a = a + 64'(atan_turns(5'(i)));
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        co = clamp1(x, 64'(Q30_ONE));
        si = clamp1(y, 64'(Q30_ONE));
    endtask

    // push the sixteen expected elements of one item's matrix (none for a skipped zero angle)
    task automatic predict_matrix(input t_in_item it);
        logic signed [63:0] comp[3];
        logic signed [63:0] unit[3];
        logic signed [63:0] el[16];
        logic [63:0]        mag[3];
        logic [63:0]        maxv;
        logic [63:0]        sum;
        logic [63:0]        root;
        logic signed [63:0] c, s, t, tx, ty, tz, v, one_out;
        logic               zero;
        int                 drop;
        t_out_item          r;
        one_out = 64'sd1 <<< OUTPUT_FRAC_BITS;
        drop = 30 - OUTPUT_FRAC_BITS;
        if (skip_zero && it.angle_deg == 0) return;
        comp[0] = 64'(it.axis_x);
        comp[1] = 64'(it.axis_y);
        comp[2] = 64'(it.axis_z);
        maxv = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = comp[k] < 0 ? 64'(-comp[k]) : 64'(comp[k]);
            if (mag[k] > maxv) maxv = mag[k];
        end
        zero = (maxv == 0);
        for (int k = 0; k < 16; k++) el[k] = 0;
        if (zero) begin
            el[0] = Q30_ONE;
            el[5] = Q30_ONE;
            el[10] = Q30_ONE;
            el[15] = Q30_ONE;
        end else begin
            // normalize up so the largest component reaches 2^30
            while (maxv < Q30_ONE) begin
                maxv = maxv << 1;
                for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
            end
            sum = 0;
            for (int k = 0; k < 3; k++) sum = sum + mag[k] * mag[k];
            root = isqrt(sum);
            for (int k = 0; k < 3; k++) begin
                v = 64'(((mag[k] << 30) + root / 2) / root);
                unit[k] = comp[k] < 0 ? -v : v;
            end
            cordic_cs(it.angle_deg, c, s);
            t = 64'(Q30_ONE) - c;
            tx = qmul(t, unit[0]);
            ty = qmul(t, unit[1]);
            tz = qmul(t, unit[2]);
            el[0] = qmul(tx, unit[0]) + c;
            el[1] = qmul(tx, unit[1]) + qmul(s, unit[2]);
            el[2] = qmul(tx, unit[2]) - qmul(s, unit[1]);
            el[4] = qmul(tx, unit[1]) - qmul(s, unit[2]);
            el[5] = qmul(ty, unit[1]) + c;
            el[6] = qmul(ty, unit[2]) + qmul(s, unit[0]);
            el[8] = qmul(tx, unit[2]) + qmul(s, unit[1]);
            el[9] = qmul(ty, unit[2]) - qmul(s, unit[0]);
            el[10] = qmul(tz, unit[2]) + c;
            el[15] = Q30_ONE;
        end
        for (int k = 0; k < 16; k++) begin
            v = el[k];
            if (drop > 0) v = fshift(v + (64'sd1 <<< (drop - 1)), drop);
            v = clamp1(v, one_out);
            r.element_index = 4'(k);
            r.element_value = v[31:0];
            r.zero_axis = zero;
            r.last = (k == 15);
            matrix_q.push_back(r);
        end
    endtask

    function automatic t_in_item mk(input logic [31:0] a, input logic [31:0] x,
                                    input logic [31:0] y, input logic [31:0] z);
        t_in_item it;
        it.angle_deg = a;
        it.axis_x = x;
        it.axis_y = y;
        it.axis_z = z;
        return it;
    endfunction

    function automatic logic [31:0] rnd_field();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 262144)) - 131072);
            3: return 32'($urandom_range(0, 3)) - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rnd_item();
        t_in_item it;
        it = mk(rnd_field(), rnd_field(), rnd_field(), rnd_field());
        case ($urandom_range(0, 19))
            0: it.angle_deg = 0;
            1: it.angle_deg = 32'(360 * 65536 * $signed($urandom_range(0, 10) - 5));
            2: it.axis_x = 0;
            3: begin
                it.axis_x = 0;
                it.axis_y = 0;
                it.axis_z = 0;
            end
            4: it.angle_deg = 32'(90 * 65536 * $urandom_range(0, 8));
            default: ;
        endcase
        return it;
    endfunction

    task automatic wait_drain();
        while (matrix_q.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_skip(input logic val);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        skip_zero = val;
    endtask

    // drive one item, holding it until it is taken; random gap before it
    task automatic send_item(input t_in_item it, input bit gap);
        if (gap && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_matrix(it);
    endtask

    task automatic check_row(input t_row row);
        t_out_item r;
        case (row.kind)
            CHK_NONE: begin
                if (matrix_q.size() != 0) begin
                    $display("%0t: zero angle predicted %0d elements, expected none",
                             $time, matrix_q.size());
                    err_cnt++;
                end
            end
            CHK_IDENT: begin
                for (int k = 0; k < 16; k++) begin
                    r = matrix_q[matrix_q.size() - 16 + k];
                    if (r.zero_axis !== 1'b1 || r.element_value !==
                        ((k % 5 == 0) ? 32'h4000_0000 : 32'h0)) begin
                        $display("%0t: identity element %0d expected %h actual %h",
                                 $time, k, (k % 5 == 0) ? 32'h4000_0000 : 32'h0,
                                 r.element_value);
                        err_cnt++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // compare each result transfer with the oldest expected element
    always @(posedge clk) begin
        t_out_item e;
        if (rst_n && out_valid && !out_stall) begin
            if (matrix_q.size() == 0) begin
                $display("%0t: unexpected element expected none actual %p", $time, out_data);
                err_cnt++;
            end else begin
                e = matrix_q.pop_front();
                if (out_data.element_index !== e.element_index) begin
                    $display("%0t: element_index expected %0d actual %0d",
                             $time, e.element_index, out_data.element_index);
                    err_cnt++;
                end
                if (out_data.element_value !== e.element_value) begin
                    $display("%0t: element %0d value expected %h actual %h",
                             $time, e.element_index, e.element_value, out_data.element_value);
                    err_cnt++;
                end
                if (out_data.zero_axis !== e.zero_axis) begin
                    $display("%0t: zero_axis expected %b actual %b",
                             $time, e.zero_axis, out_data.zero_axis);
                    err_cnt++;
                end
                if (out_data.last !== e.last) begin
                    $display("%0t: last expected %b actual %b", $time, e.last, out_data.last);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stall pattern: phases of none, light, heavy and periodic stall
    always @(posedge clk) begin
        int cnt;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_mode <= 0;
            cnt = 0;
        end else begin
            cnt++;
            if (cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 7) == 0);
                2: out_stall <= ($urandom_range(0, 2) != 0);
                default: out_stall <= (cnt % 5 < 2);
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("axis_angle_rotation_matrix verification failed");
                $finish;
            end
        end
    end

    initial begin
        rows[0]  = '{CHK_NONE,  1'b1, mk(32'h0, 32'h0001_0000, 32'h0, 32'h0)};
        rows[1]  = '{CHK_PRED,  1'b1, mk(32'h005A_0000, 32'h0001_0000, 32'h0, 32'h0)};
        rows[2]  = '{CHK_IDENT, 1'b1, mk(32'h005A_0000, 32'h0, 32'h0, 32'h0)};
        rows[3]  = '{CHK_PRED,  1'b1, mk(32'h0168_0000, 32'h0, 32'h0, 32'h0001_0000)};
        rows[4]  = '{CHK_PRED,  1'b1, mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF)};
        rows[5]  = '{CHK_PRED,  1'b1, mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000)};
        rows[6]  = '{CHK_PRED,  1'b1, mk(32'h00B4_0000, 32'h0, 32'h1, 32'h0)};
        rows[7]  = '{CHK_PRED,  1'b1, mk(32'hFFA6_0000, 32'hFFFF_FFFF, 32'h0, 32'h0)};
        rows[8]  = '{CHK_PRED,  1'b1, mk(32'h0000_0001, 32'h1, 32'h1, 32'h1)};
        rows[9]  = '{CHK_PRED,  1'b1, mk(32'hFE98_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h1)};
        rows[10] = '{CHK_IDENT, 1'b0, mk(32'h0, 32'h0, 32'h0, 32'h0)};
        rows[11] = '{CHK_PRED,  1'b0, mk(32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0)};
        rows[12] = '{CHK_PRED,  1'b0, mk(32'h010E_0000, 32'h0, 32'hFFFF_0000, 32'h0)};
        rows[13] = '{CHK_PRED,  1'b0, mk(32'h002D_8000, 32'h1234_5678, 32'h9ABC_DEF0,
                                        32'h0F0F_0F0F)};
        rows[14] = '{CHK_IDENT, 1'b0, mk(32'h8000_0000, 32'h0, 32'h0, 32'h0)};
        rows[15] = '{CHK_PRED,  1'b0, mk(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000)};
        rows[16] = '{CHK_PRED,  1'b0, mk(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                                        32'h0)};
        rows[17] = '{CHK_PRED,  1'b0, mk(32'h0087_0000, 32'h0, 32'h7FFF_FFFF, 32'h0)};
        rows[18] = '{CHK_PRED,  1'b0, mk(32'h00B4_0001, 32'h0003_0000, 32'h0004_0000,
                                        32'h0)};
        rows[19] = '{CHK_PRED,  1'b0, mk(32'h013B_0000, 32'h0, 32'h0, 32'hFFFF_FFFF)};

        err_cnt = 0;
        skip_zero = 1'b1;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value holds the rotate rule; switch only at the table's boundary
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (rows[i].skip != skip_zero) begin
                in_valid <= 1'b0;
                wait_drain();
                write_skip(rows[i].skip);
            end
            send_item(rows[i].item, 1'b0);
            check_row(rows[i]);
        end

        // random phases alternating the rule, ending at each extreme
        for (int ph = 0; ph < 4; ph++) begin
            in_valid <= 1'b0;
            wait_drain();
            write_skip(ph[0]);
            for (int i = 0; i < N_RANDOM / 4; i++) send_item(rnd_item(), 1'b1);
        end
        in_valid <= 1'b0;
        wait_drain();

        if (err_cnt == 0) begin
            $display("axis_angle_rotation_matrix verification clean");
        end else begin
            $display("axis_angle_rotation_matrix verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/aarm_pkg.sv
rtl/axis_angle_rotation_matrix.sv
tb/axis_angle_rotation_matrix_tb.sv
